[src/qrs_pkg.sv]
// shared types and constants for the quadratic root solver
package qrs_pkg;

  localparam int CoefW    = 32;
  localparam int RootW    = 32;
  localparam int TolW     = 31;
  localparam int DiscW    = 67;
  localparam int RadW     = 66;
  localparam int SqrtW    = 33;
  localparam int SqrtRemW = 34;
  localparam int NumW     = 36;
  localparam int NumMagW  = 35;
  localparam int DenW     = 33;
  localparam int QuotW    = 33;

  typedef enum logic [1:0] {
    KIND_INF  = 2'd0,
    KIND_NONE = 2'd1,
    KIND_ONE  = 2'd2,
    KIND_TWO  = 2'd3
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } meta_t;

  typedef struct packed {
    meta_t                   meta;
    logic signed [NumW-1:0]  num0;
    logic signed [NumW-1:0]  negb;
    logic signed [DenW-1:0]  den;
  } side_t;

endpackage

[src/qrs_front.sv]
// products, discriminant and classification of one coefficient set
module qrs_front import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic signed [CoefW-1:0] coef_quad,
  input  logic signed [CoefW-1:0] coef_lin,
  input  logic signed [CoefW-1:0] coef_const,
  input  logic        [TolW-1:0]  tolerance,
  output logic        [RadW-1:0]  rad,
  output side_t                   side
);

  // stage 1: input registers
  logic                    v1;
  logic signed [CoefW-1:0] a1, b1, c1;

  always_ff @(posedge clk) begin
    a1 <= coef_quad;
    b1 <= coef_lin;
    c1 <= coef_const;
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  // magnitudes and effective tolerance
  logic [TolW-1:0]  tol_eff;
  logic [CoefW-1:0] ma, mb, mc;

  always_comb begin
    tol_eff = (tolerance == '0) ? TolW'(1) : tolerance;
    ma = a1[CoefW-1] ? CoefW'(-a1) : CoefW'(a1);
    mb = b1[CoefW-1] ? CoefW'(-b1) : CoefW'(b1);
    mc = c1[CoefW-1] ? CoefW'(-c1) : CoefW'(c1);
  end

  // stage 2: products and near-zero flags
  logic                      v2, az2, bz2, cz2;
  logic signed [CoefW-1:0]   a2, b2, c2;
  logic signed [2*CoefW-1:0] bb2, ac2;

  always_ff @(posedge clk) begin
    a2  <= a1;
    b2  <= b1;
    c2  <= c1;
    bb2 <= b1 * b1;
    ac2 <= a1 * c1;
    az2 <= ma < CoefW'(tol_eff);
    bz2 <= mb < CoefW'(tol_eff);
    cz2 <= mc < CoefW'(tol_eff);
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  // stage 3: discriminant b*b - 4*a*c
  logic                    v3, az3, bz3, cz3;
  logic signed [CoefW-1:0] a3, b3, c3;
  logic signed [DiscW-1:0] d3;

  always_ff @(posedge clk) begin
    a3  <= a2;
    b3  <= b2;
    c3  <= c2;
    az3 <= az2;
    bz3 <= bz2;
    cz3 <= cz2;
    d3  <= DiscW'(bb2) - (DiscW'(ac2) <<< 2);
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  // classification against the scaled tolerance
  logic signed [DiscW-1:0] thr;
  kind_t                   kind;

  always_comb begin
    thr = $signed(DiscW'(tol_eff) << FRAC_BITS);
    if (az3 && bz3 && cz3) begin
      kind = KIND_INF;
    end else if (az3 && bz3) begin
      kind = KIND_NONE;
    end else if (az3) begin
      kind = KIND_ONE;
    end else if (d3 <= -thr) begin
      kind = KIND_NONE;
    end else if (d3 < thr) begin
      kind = KIND_ONE;
    end else begin
      kind = KIND_TWO;
    end
  end

  // stage 4: radicand and divider operands
  always_ff @(posedge clk) begin
    rad       <= (kind == KIND_TWO) ? d3[RadW-1:0] : '0;
    side.meta.kind <= kind;
    side.negb <= -(NumW'(b3));
    side.num0 <= az3 ? -(NumW'(c3)) : -(NumW'(b3));
    side.den  <= az3 ? DenW'(b3) : $signed({a3, 1'b0});
    if (rst) begin
      side.meta.valid <= 1'b0;
    end else begin
      side.meta.valid <= v3;
    end
  end

endmodule

[src/qrs_sqrt.sv]
// pipelined integer square root, one root bit per stage
module qrs_sqrt import qrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [RadW-1:0]  rad,
  input  side_t            side_in,
  output logic [SqrtW-1:0] root,
  output side_t            side_out
);

  logic [SqrtRemW-1:0] rem_q  [SqrtW];
  logic [SqrtW-1:0]    root_q [SqrtW];
  logic [RadW-1:0]     rad_q  [SqrtW];
  side_t               side_q [SqrtW];

  for (genvar k = 0; k < SqrtW; k++) begin : g_step
    logic [SqrtRemW-1:0] rem_in;
    logic [SqrtW-1:0]    root_in;
    logic [RadW-1:0]     rad_in;
    side_t               side_k;
    logic [SqrtRemW+1:0] rem_sh, trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign side_k  = side_in;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
      assign side_k  = side_q[k-1];
    end

    // trial subtract of 4*root+1
    always_comb begin
      rem_sh = {rem_in, rad_in[RadW-1:RadW-2]};
      trial  = {1'b0, root_in, 2'b01};
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? SqrtRemW'(rem_sh - trial) : SqrtRemW'(rem_sh);
      root_q[k] <= {root_in[SqrtW-2:0], ge};
      rad_q[k]  <= rad_in << 2;
      side_q[k].meta.kind <= side_k.meta.kind;
      side_q[k].num0      <= side_k.num0;
      side_q[k].negb      <= side_k.negb;
      side_q[k].den       <= side_k.den;
      if (rst) begin
        side_q[k].meta.valid <= 1'b0;
      end else begin
        side_q[k].meta.valid <= side_k.meta.valid;
      end
    end
  end

  assign root     = root_q[SqrtW-1];
  assign side_out = side_q[SqrtW-1];

endmodule

[src/qrs_div.sv]
// pipelined fixed-point divider lane with truncation and saturation
module qrs_div import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic signed [NumW-1:0]  num,
  input  logic signed [DenW-1:0]  den,
  input  meta_t                   meta_in,
  output logic signed [RootW-1:0] quot,
  output logic                    sat,
  output meta_t                   meta_out
);

  localparam int NW = NumMagW + FRAC_BITS;

  // operand magnitudes, scaled numerator
  logic [NumMagW-1:0] mag_n;
  logic [DenW-1:0]    mag_d;
  logic [NW-1:0]      n_sh;
  logic [DenW-1:0]    rem_init;

  always_comb begin
    mag_n    = num[NumW-1] ? NumMagW'(-num) : NumMagW'(num);
    mag_d    = den[DenW-1] ? DenW'(-den) : DenW'(den);
    n_sh     = NW'(mag_n) << FRAC_BITS;
    rem_init = DenW'(n_sh[NW-1:QuotW]);
  end

  // prep stage
  logic [DenW-1:0]  p_rem, p_den;
  logic [QuotW-1:0] p_low;
  logic             p_neg, p_big;
  meta_t            p_meta;

  always_ff @(posedge clk) begin
    p_big  <= rem_init >= mag_d;
    p_rem  <= (rem_init >= mag_d) ? '0 : rem_init;
    p_low  <= n_sh[QuotW-1:0];
    p_den  <= mag_d;
    p_neg  <= num[NumW-1] ^ den[DenW-1];
    p_meta.kind <= meta_in.kind;
    if (rst) begin
      p_meta.valid <= 1'b0;
    end else begin
      p_meta.valid <= meta_in.valid;
    end
  end

  // restoring steps, one quotient bit each
  logic [DenW-1:0]  rem_q  [QuotW];
  logic [QuotW-1:0] low_q  [QuotW];
  logic [QuotW-1:0] q_q    [QuotW];
  logic [DenW-1:0]  den_q  [QuotW];
  logic             neg_q  [QuotW];
  logic             big_q  [QuotW];
  meta_t            meta_q [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [DenW-1:0]  rem_in, den_in;
    logic [QuotW-1:0] low_in, q_in;
    logic             neg_in, big_in;
    meta_t            meta_k;
    logic [DenW:0]    rem_sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = p_rem;
      assign low_in = p_low;
      assign q_in   = '0;
      assign den_in = p_den;
      assign neg_in = p_neg;
      assign big_in = p_big;
      assign meta_k = p_meta;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign q_in   = q_q[k-1];
      assign den_in = den_q[k-1];
      assign neg_in = neg_q[k-1];
      assign big_in = big_q[k-1];
      assign meta_k = meta_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_in, low_in[QuotW-1]};
      ge     = rem_sh >= {1'b0, den_in};
    end

    always_ff @(posedge clk) begin
      rem_q[k]  <= ge ? DenW'(rem_sh - {1'b0, den_in}) : DenW'(rem_sh);
      low_q[k]  <= low_in << 1;
      q_q[k]    <= {q_in[QuotW-2:0], ge};
      den_q[k]  <= den_in;
      neg_q[k]  <= neg_in;
      big_q[k]  <= big_in;
      meta_q[k].kind <= meta_k.kind;
      if (rst) begin
        meta_q[k].valid <= 1'b0;
      end else begin
        meta_q[k].valid <= meta_k.valid;
      end
    end
  end

  // saturation and sign
  logic [QuotW-1:0] qm;
  logic             f_neg, f_sat;

  always_comb begin
    qm    = q_q[QuotW-1];
    f_neg = neg_q[QuotW-1];
    f_sat = big_q[QuotW-1] ||
            (!f_neg && (qm[QuotW-1:RootW-1] != '0)) ||
            (f_neg && (qm > (QuotW'(1) << (RootW-1))));
  end

  always_ff @(posedge clk) begin
    sat      <= f_sat;
    meta_out.kind <= meta_q[QuotW-1].kind;
    if (f_sat) begin
      quot <= f_neg ? {1'b1, {(RootW-1){1'b0}}} : {1'b0, {(RootW-1){1'b1}}};
    end else begin
      quot <= f_neg ? RootW'(-qm) : RootW'(qm);
    end
    if (rst) begin
      meta_out.valid <= 1'b0;
    end else begin
      meta_out.valid <= meta_q[QuotW-1].valid;
    end
  end

endmodule

[src/quadratic_root_solver_core.sv]
// top level of the quadratic root solver
//
//  port group        dir  handshake                 payload
//  coefficients      in   start, busy (always low)  coef_quad, coef_lin, coef_const
//  tolerance         in   tolerance_write           tolerance
//  result            out  done strobe, one cycle    solution_kind, root_low,
//                                                   root_high, overflow
//
// one item enters each cycle; done rises once for each accepted item
// items pass the front end, the 33-stage square root and the 35-stage divider lanes
// busy is tied low: the pipeline never stalls and results are never held
// rst clears all valid bits and loads the tolerance with its default
module quadratic_root_solver_core import qrs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [CoefW-1:0] coef_quad,
  input  logic signed [CoefW-1:0] coef_lin,
  input  logic signed [CoefW-1:0] coef_const,
  input  logic                    tolerance_write,
  input  logic        [TolW-1:0]  tolerance,
  output logic                    done,
  output logic        [1:0]       solution_kind,
  output logic signed [RootW-1:0] root_low,
  output logic signed [RootW-1:0] root_high,
  output logic                    overflow
);

  localparam logic [TolW-1:0] TolReset = TolW'(66);

  assign busy = 1'b0;

  // tolerance register
  logic [TolW-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TolReset;
    end else if (tolerance_write) begin
      tol <= tolerance;
    end
  end

  // classification front end
  logic [RadW-1:0] rad;
  side_t           f_side;

  qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start & ~busy),
    .coef_quad  (coef_quad),
    .coef_lin   (coef_lin),
    .coef_const (coef_const),
    .tolerance  (tol),
    .rad        (rad),
    .side       (f_side)
  );

  // square root of the discriminant
  logic [SqrtW-1:0] root;
  side_t            s_side;

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .rad      (rad),
    .side_in  (f_side),
    .root     (root),
    .side_out (s_side)
  );

  // numerators for both lanes
  logic signed [NumW-1:0] num0, num1, sd;
  logic signed [DenW-1:0] den;
  meta_t                  m_meta;

  assign sd = $signed(NumW'(root));

  always_ff @(posedge clk) begin
    num0   <= (s_side.meta.kind == KIND_TWO) ? s_side.negb - sd : s_side.num0;
    num1   <= s_side.negb + sd;
    den    <= s_side.den;
    m_meta.kind <= s_side.meta.kind;
    if (rst) begin
      m_meta.valid <= 1'b0;
    end else begin
      m_meta.valid <= s_side.meta.valid;
    end
  end

  // divider lanes
  logic signed [RootW-1:0] q0, q1;
  logic                    sat0, sat1;
  meta_t                   d_meta0, d_meta1;

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_low (
    .clk      (clk),
    .rst      (rst),
    .num      (num0),
    .den      (den),
    .meta_in  (m_meta),
    .quot     (q0),
    .sat      (sat0),
    .meta_out (d_meta0)
  );

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div_high (
    .clk      (clk),
    .rst      (rst),
    .num      (num1),
    .den      (den),
    .meta_in  (m_meta),
    .quot     (q1),
    .sat      (sat1),
    .meta_out (d_meta1)
  );

  // result register
  logic has_root, two_roots;

  always_comb begin
    has_root  = (d_meta0.kind == KIND_ONE) || (d_meta0.kind == KIND_TWO);
    two_roots = (d_meta1.kind == KIND_TWO);
  end

  always_ff @(posedge clk) begin
    solution_kind <= d_meta0.kind;
    root_low      <= has_root ? q0 : '0;
    root_high     <= two_roots ? q1 : '0;
    overflow      <= (has_root & sat0) | (two_roots & sat1);
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_meta0.valid;
    end
  end

endmodule

[tb/tb_quadratic_root_solver_core.sv]
// testbench for the quadratic root solver core: random and directed coefficient sets
module tb_quadratic_root_solver_core import qrs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 74;

  typedef struct {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } coef_set_t;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               ovf;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] coef_quad = '0;
  logic signed [31:0] coef_lin = '0;
  logic signed [31:0] coef_const = '0;
  logic tolerance_write = 1'b0;
  logic [30:0] tolerance = 31'd66;
  logic done;
  logic [1:0] solution_kind;
  logic signed [31:0] root_low;
  logic signed [31:0] root_high;
  logic overflow;

  coef_set_t pending_sets[$];
  roots_t expected_roots[$];
  logic [30:0] cur_tol = 31'd66;
  int errors = 0;
  int sets_sent = 0;
  int roots_seen = 0;
  int kind_count[4] = '{0, 0, 0, 0};
  int gap = 0;

  quadratic_root_solver_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coef_quad(coef_quad), .coef_lin(coef_lin), .coef_const(coef_const),
    .tolerance_write(tolerance_write), .tolerance(tolerance),
    .done(done), .solution_kind(solution_kind), .root_low(root_low),
    .root_high(root_high), .overflow(overflow)
  );

  always #2 clk = ~clk;

  // fixed point quotient (num << 16) / den, truncated, saturated
  function automatic logic signed [31:0] sat_quot(input longint num, input longint den,
                                                  inout logic ovf);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (q < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic roots_t solve_roots(input coef_set_t s, input logic [30:0] tol_reg);
    roots_t r;
    longint a, b, c, tol, t, q, d, sd;
    longint unsigned bm, bb, rr, sr, ss, sq;
    logic az, bz, cz;
    int cls;
    a = s.a; b = s.b; c = s.c;
    tol = (tol_reg == 0) ? 1 : longint'(tol_reg);
    az = ((a < 0) ? -a : a) < tol;
    bz = ((b < 0) ? -b : b) < tol;
    cz = ((c < 0) ? -c : c) < tol;
    r.lo = '0; r.hi = '0; r.ovf = 1'b0;
    if (az && bz && cz) begin
      r.kind = KIND_INF;
    end else if (az && bz) begin
      r.kind = KIND_NONE;
    end else if (az) begin
      r.kind = KIND_ONE;
      r.lo = sat_quot(-c, b, r.ovf);
    end else begin
      bm = (b < 0) ? -b : b;
      bb = bm * bm;
      q = longint'(bb >> 2) - a * c;
      rr = bb & 64'd3;
      t = tol * 65536;
      if (q >= (64'sd1 <<< 60)) cls = 3;
      else if (q <= -(64'sd1 <<< 60)) cls = 1;
      else begin
        d = q * 4 + longint'(rr);
        if (d <= -t) cls = 1;
        else if (d < t) cls = 2;
        else cls = 3;
      end
      if (cls == 1) begin
        r.kind = KIND_NONE;
      end else if (cls == 2) begin
        r.kind = KIND_ONE;
        r.lo = sat_quot(-b, 2 * a, r.ovf);
      end else begin
        sr = floor_sqrt(longint'(q));
        ss = sr * sr + sr;
        sq = 2 * sr;
        if (ss < longint'(q) || (ss == longint'(q) && rr == 1)) sq += 1;
        sd = longint'(sq);
        r.kind = KIND_TWO;
        r.lo = sat_quot(-b - sd, 2 * a, r.ovf);
        r.hi = sat_quot(-b + sd, 2 * a, r.ovf);
      end
    end
    return r;
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 800)) - 400;
      2: return $signed($urandom_range(0, 2000000)) - 1000000;
      3: return $signed($urandom_range(0, 600)) * 65536 - 300 * 65536;
      4: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'sh0;
    endcase
  endfunction

  // driver: feeds queued sets with random gaps
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_roots.push_back(solve_roots('{coef_quad, coef_lin, coef_const}, cur_tol));
      sets_sent++;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap == 0 && pending_sets.size() > 0) begin
        coef_set_t s;
        s = pending_sets.pop_front();
        coef_quad <= s.a; coef_lin <= s.b; coef_const <= s.c;
      end else begin
        start <= 1'b0;
        if (gap > 0) gap--;
      end
    end else if (!start) begin
      if (gap > 0) gap--;
      else if (pending_sets.size() > 0) begin
        coef_set_t s;
        s = pending_sets.pop_front();
        coef_quad <= s.a; coef_lin <= s.b; coef_const <= s.c;
        start <= 1'b1;
      end
    end
  end

  // monitor: compare each strobed result with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      roots_seen++;
      if (expected_roots.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d", $time, solution_kind);
      end else begin
        roots_t e;
        e = expected_roots.pop_front();
        kind_count[e.kind]++;
        if (solution_kind !== e.kind || root_low !== e.lo || root_high !== e.hi ||
            overflow !== e.ovf) begin
          errors++;
          $display("%0t: mismatch expected kind %0d lo %h hi %h ovf %b, got %0d %h %h %b",
                   $time, e.kind, e.lo, e.hi, e.ovf, solution_kind, root_low,
                   root_high, overflow);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_sets.size() > 0 || start || expected_roots.size() > 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic write_tol(input logic [30:0] v);
    @(posedge clk);
    tolerance <= v;
    tolerance_write <= 1'b1;
    @(posedge clk);
    tolerance_write <= 1'b0;
    cur_tol = v;
  endtask

  task automatic queue_random(input int n);
    coef_set_t s;
    repeat (n) begin
      s.a = rand_coef(); s.b = rand_coef(); s.c = rand_coef();
      pending_sets.push_back(s);
    end
  endtask

  initial begin
    coef_set_t s;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // directed: each kind, extremes and tolerance edges at the reset tolerance
    pending_sets.push_back('{0, 0, 0});
    pending_sets.push_back('{65, -65, 65});
    pending_sets.push_back('{0, 0, 66});
    pending_sets.push_back('{0, 66, 65536});
    pending_sets.push_back('{0, 66, 32'sh7fffffff});
    pending_sets.push_back('{65536, -131072, 65536});
    pending_sets.push_back('{65536, 0, 65536});
    pending_sets.push_back('{65536, 0, -65536});
    pending_sets.push_back('{65536, -196608, 131072});
    pending_sets.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000});
    pending_sets.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    pending_sets.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh80000000});
    pending_sets.push_back('{66, 32'sh7fffffff, 32'sh80000000});
    pending_sets.push_back('{-66, 32'sh80000000, 32'sh7fffffff});
    pending_sets.push_back('{1000, 100, 2});
    pending_sets.push_back('{-1, -1, -1});
    pending_sets.push_back('{32'shffffffff, 32'shaaaaaaaa, 32'h55555555});
    queue_random(200);
    wait_drained();
    write_tol(31'd1);
    pending_sets.push_back('{1, 0, 0});
    pending_sets.push_back('{0, 1, 0});
    queue_random(150);
    wait_drained();
    write_tol(31'h7fffffff);
    pending_sets.push_back('{32'sh80000000, 32'sh80000001, 5});
    queue_random(100);
    wait_drained();
    write_tol(31'($urandom_range(1, 70000)));
    queue_random(100);
    wait_drained();
    write_tol(31'd66);
    queue_random(80);
    wait_drained();
    $display("sent %0d coefficient sets, checked %0d results over five tolerances",
             sets_sent, roots_seen);
    $display("kinds seen: infinite %0d, none %0d, one %0d, two %0d",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver_core test passed");
    end else begin
      $display("quadratic_root_solver_core test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("quadratic_root_solver_core test failed");
    $finish;
  end
endmodule
